>>> hw/rtl/blxyz_pkg.sv
// Shared constants for the block-linear offset to xyz unit.
// No dependencies.
package blxyz_pkg;
   localparam int COORD_W  = 17;   // coordinate and divisor width
   localparam int NUM_W    = 23;   // block index width (32-bit offset over 512-byte groups)
   localparam int GROUP_W  = 15;   // group index inside a block
   localparam int LOG_W    = 3;
   localparam int OFS_W    = 32;
   localparam int GROUP_LOG = 9;   // 512-byte groups
   localparam int CSR_IDX_W = 3;

   localparam logic [LOG_W-1:0] MAX_BLOCK_LOG = 3'd5;
   localparam logic [LOG_W-1:0] MAX_PIXEL_LOG = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LBW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LBH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LBD    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LBPP   = 3'd6;
endpackage

>>> hw/rtl/blxyz_div_cell.sv
// One restoring-division cell: one quotient bit per cell, registered.
// Depends on blxyz_pkg.
module blxyz_div_cell #(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   input  logic [blxyz_pkg::COORD_W-1:0] in_rem,
   input  logic [blxyz_pkg::NUM_W-1:0]   in_num,
   input  logic [SIDE_W-1:0]             in_side,
   input  logic [blxyz_pkg::COORD_W-1:0] divisor,
   output logic                          out_vld,
   output logic [blxyz_pkg::COORD_W-1:0] out_rem,
   output logic [blxyz_pkg::NUM_W-1:0]   out_num,
   output logic [SIDE_W-1:0]             out_side
);
   logic                          vld_ff;
   logic [blxyz_pkg::COORD_W-1:0] rem_ff, rem_in;
   logic [blxyz_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [SIDE_W-1:0]             side_ff;
   logic [blxyz_pkg::COORD_W:0]   trial, diff;
   logic                          ge;

   always_comb begin
      trial  = {in_rem, in_num[blxyz_pkg::NUM_W-1]};
      diff   = trial - {1'b0, divisor};
      ge     = trial >= {1'b0, divisor};
      rem_in = ge ? diff[blxyz_pkg::COORD_W-1:0] : trial[blxyz_pkg::COORD_W-1:0];
      num_in = {in_num[blxyz_pkg::NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      side_ff <= in_side;
   end

   assign out_vld  = vld_ff;
   assign out_rem  = rem_ff;
   assign out_num  = num_ff;
   assign out_side = side_ff;
endmodule

>>> hw/rtl/blxyz_divider.sv
// Pipelined divider: a chain of NUM_W division cells, side data rides along.
// Depends on blxyz_pkg and blxyz_div_cell.
module blxyz_divider #(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   input  logic [blxyz_pkg::NUM_W-1:0]   in_num,
   input  logic [SIDE_W-1:0]             in_side,
   input  logic [blxyz_pkg::COORD_W-1:0] divisor,
   output logic                          out_vld,
   output logic [blxyz_pkg::NUM_W-1:0]   out_quot,
   output logic [blxyz_pkg::COORD_W-1:0] out_rem,
   output logic [SIDE_W-1:0]             out_side
);
   logic                          vld  [0:blxyz_pkg::NUM_W];
   logic [blxyz_pkg::COORD_W-1:0] rem  [0:blxyz_pkg::NUM_W];
   logic [blxyz_pkg::NUM_W-1:0]   num  [0:blxyz_pkg::NUM_W];
   logic [SIDE_W-1:0]             side [0:blxyz_pkg::NUM_W];

   assign vld[0]  = in_vld;
   assign rem[0]  = '0;
   assign num[0]  = in_num;
   assign side[0] = in_side;

   for (genvar i = 0; i < blxyz_pkg::NUM_W; i++) begin : g_cell
      blxyz_div_cell #(.SIDE_W(SIDE_W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .in_vld  (vld[i]),
         .in_rem  (rem[i]),
         .in_num  (num[i]),
         .in_side (side[i]),
         .divisor (divisor),
         .out_vld (vld[i+1]),
         .out_rem (rem[i+1]),
         .out_num (num[i+1]),
         .out_side(side[i+1])
      );
   end

   assign out_vld  = vld[blxyz_pkg::NUM_W];
   assign out_quot = num[blxyz_pkg::NUM_W];
   assign out_rem  = rem[blxyz_pkg::NUM_W];
   assign out_side = side[blxyz_pkg::NUM_W];
endmodule

>>> hw/rtl/block_linear_offset_to_xyz_unit.sv
// Top level of the block-linear offset to xyz unit.
// Depends on blxyz_pkg and blxyz_divider (which uses blxyz_div_cell).
//
// Usage: the unit takes one byte offset per cycle (busy is always low) and
// returns pixel coordinates after the offset passes the input register,
// three chained 23-cell division pipelines (block index over the block
// counts in x, y and z) and the output register. rsp_valid strobes
// for one cycle per transfer; the receiver cannot stall it. Write the
// configuration registers only while no offset is in flight; a start may
// follow a write on the very next cycle.
module block_linear_offset_to_xyz_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [blxyz_pkg::OFS_W-1:0]       req_byte_offset,
   output logic                              rsp_valid,
   output logic [blxyz_pkg::COORD_W-1:0]     rsp_pos_x,
   output logic [blxyz_pkg::COORD_W-1:0]     rsp_pos_y,
   output logic [blxyz_pkg::COORD_W-1:0]     rsp_pos_z,
   input  logic                              csr_we,
   input  logic [blxyz_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [blxyz_pkg::COORD_W-1:0]     csr_wdata
);
   localparam int CW = blxyz_pkg::COORD_W;
   localparam int NW = blxyz_pkg::NUM_W;
   localparam int GW = blxyz_pkg::GROUP_W;
   localparam int LW = blxyz_pkg::LOG_W;

   // configuration registers
   logic [CW-1:0] width_ff, height_ff;
   logic [14:0]   depth_ff;
   logic [LW-1:0] lbw_ff, lbh_ff, lbd_ff, lbpp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 17'd1;
         height_ff <= 17'd1;
         depth_ff  <= 15'd1;
         lbw_ff    <= 3'd0;
         lbh_ff    <= 3'd0;
         lbd_ff    <= 3'd0;
         lbpp_ff   <= 3'd2;
      end else if (csr_we) begin
         unique case (csr_index)
            blxyz_pkg::REG_WIDTH:  width_ff  <= csr_wdata;
            blxyz_pkg::REG_HEIGHT: height_ff <= csr_wdata;
            blxyz_pkg::REG_DEPTH:  depth_ff  <= csr_wdata[14:0];
            blxyz_pkg::REG_LBW:    lbw_ff    <= csr_wdata[LW-1:0];
            blxyz_pkg::REG_LBH:    lbh_ff    <= csr_wdata[LW-1:0];
            blxyz_pkg::REG_LBD:    lbd_ff    <= csr_wdata[LW-1:0];
            blxyz_pkg::REG_LBPP:   lbpp_ff   <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // derived geometry, registered once; the user must keep config static while offsets are
   // in flight (not enforced); the divisors are first used behind the input register
   logic [LW-1:0] bw, bh, bd, bp;
   logic [3:0]    xlog_in, xlog_ff;     // log2 of block width in pixels
   logic [3:0]    ylog_in, ylog_ff;     // log2 of block height in rows
   logic [LW-1:0] bh_ff, bd_ff;
   logic [4:0]    shift_in;             // block index shift beyond the group, unregistered
   logic [CW:0]   w1, h1, d1, xsum, ysum, zsum;
   logic [CW-1:0] xb_in, yb_in, zb_in, xb_ff, yb_ff, zb_ff;

   always_comb begin
      bw = (lbw_ff  > blxyz_pkg::MAX_BLOCK_LOG) ? blxyz_pkg::MAX_BLOCK_LOG : lbw_ff;
      bh = (lbh_ff  > blxyz_pkg::MAX_BLOCK_LOG) ? blxyz_pkg::MAX_BLOCK_LOG : lbh_ff;
      bd = (lbd_ff  > blxyz_pkg::MAX_BLOCK_LOG) ? blxyz_pkg::MAX_BLOCK_LOG : lbd_ff;
      bp = (lbpp_ff > blxyz_pkg::MAX_PIXEL_LOG) ? blxyz_pkg::MAX_PIXEL_LOG : lbpp_ff;
      xlog_in  = 4'd6 - {1'b0, bp} + {1'b0, bw};
      ylog_in  = 4'd3 + {1'b0, bh};
      shift_in = {2'b0, bw} + {2'b0, bh} + {2'b0, bd};
      w1 = (width_ff  == '0) ? 18'd1 : {1'b0, width_ff};
      h1 = (height_ff == '0) ? 18'd1 : {1'b0, height_ff};
      d1 = (depth_ff  == '0) ? 18'd1 : {3'b0, depth_ff};
      // ceiling division by a power of two
      xsum  = w1 + ((18'd1 << xlog_in) - 18'd1);
      ysum  = h1 + ((18'd1 << ylog_in) - 18'd1);
      zsum  = d1 + ((18'd1 << bd) - 18'd1);
      xb_in = CW'(xsum >> xlog_in);
      yb_in = CW'(ysum >> ylog_in);
      zb_in = CW'(zsum >> bd);
   end

   always_ff @(posedge clock) begin
      xlog_ff  <= xlog_in;
      ylog_ff  <= ylog_in;
      bh_ff    <= bh;
      bd_ff    <= bd;
      xb_ff    <= xb_in;
      yb_ff    <= yb_in;
      zb_ff    <= zb_in;
   end

   // input stage: split offset into block index and group index
   logic          in_vld_ff;
   logic [NW-1:0] bidx_ff;
   logic [GW-1:0] gidx_ff;
   logic [NW-1:0] grp_all;

   assign busy    = 1'b0;
   assign grp_all = req_byte_offset[blxyz_pkg::OFS_W-1:blxyz_pkg::GROUP_LOG];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start;
      end
      bidx_ff <= grp_all >> shift_in;
      gidx_ff <= GW'(grp_all & ((NW'(1) << shift_in) - NW'(1)));
   end

   // bx = bi % xb ; by = (bi / xb) % yb ; bz = ((bi / xb) / yb) % zb
   logic          v1, v2, v3;
   logic [NW-1:0] q1, q2, q3;
   logic [CW-1:0] r1, r2, r3;
   logic [GW-1:0] s1;
   logic [GW+CW-1:0] s2;
   logic [GW+2*CW-1:0] s3;

   blxyz_divider #(.SIDE_W(GW)) u_div_x (
      .clock(clock), .reset(reset),
      .in_vld(in_vld_ff), .in_num(bidx_ff), .in_side(gidx_ff), .divisor(xb_ff),
      .out_vld(v1), .out_quot(q1), .out_rem(r1), .out_side(s1)
   );

   blxyz_divider #(.SIDE_W(GW+CW)) u_div_y (
      .clock(clock), .reset(reset),
      .in_vld(v1), .in_num(q1), .in_side({r1, s1}), .divisor(yb_ff),
      .out_vld(v2), .out_quot(q2), .out_rem(r2), .out_side(s2)
   );

   blxyz_divider #(.SIDE_W(GW+2*CW)) u_div_z (
      .clock(clock), .reset(reset),
      .in_vld(v2), .in_num(q2), .in_side({r2, s2}), .divisor(zb_ff),
      .out_vld(v3), .out_quot(q3), .out_rem(r3), .out_side(s3)
   );

   // output stage: scale block positions, add in-block rows and slices
   logic [GW-1:0] gi;
   logic [CW-1:0] bx, by, ymask, x_in, y_in, z_in;
   logic [CW-1:0] x_ff, y_ff, z_ff;
   logic          out_vld_ff;
   logic [GW+2:0] gi8;

   always_comb begin
      gi    = s3[GW-1:0];
      bx    = s3[GW+CW-1:GW];
      by    = s3[GW+2*CW-1:GW+CW];
      gi8   = {gi, 3'b000};
      ymask = (CW'(1) << ylog_ff) - CW'(1);
      x_in  = bx << xlog_ff;
      y_in  = (by << ylog_ff) + (CW'(gi8) & ymask);
      z_in  = (r3 << bd_ff) + CW'(gi >> bh_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= v3;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_pos_x = x_ff;
   assign rsp_pos_y = y_ff;
   assign rsp_pos_z = z_ff;

   // q3 is not needed: bz is the remainder of the last division
   logic unused_q3;
   assign unused_q3 = ^q3;
endmodule
